FILE: sv/rgb_to_palette_index_quantizer_unit_macros.svh
// Assertion macros for the palette quantizer.
// Included by the top level; every macro expects aclk and aresetn in scope.
`ifndef RGB_TO_PALETTE_INDEX_QUANTIZER_UNIT_MACROS_SVH
`define RGB_TO_PALETTE_INDEX_QUANTIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RTPQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define RTPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rtpq_pkg.sv
// Shared constants and the color distance function of the palette quantizer.
// No dependencies.
package rtpq_pkg;

    localparam int KEY_W  = 24;
    localparam int DIST_W = 14;

    localparam logic [7:0]        TRANSPARENT_IDX = 8'd0;
    localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};

    // Squared 5-bit component difference, at most 31*31
    function automatic logic [9:0] sq_diff5(input logic [4:0] a, input logic [4:0] b);
        logic [4:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return 10'(d * d);
    endfunction

    // Weighted distance 2*dr^2 + 4*dg^2 + 3*db^2 on the top 5 bits of each channel
    function automatic logic [DIST_W-1:0] weighted_dist(input logic [KEY_W-1:0] ka,
                                                       input logic [KEY_W-1:0] kb);
        logic [9:0] sr;
        logic [9:0] sg;
        logic [9:0] sb;
        sr = sq_diff5(ka[23:19], kb[23:19]);
        sg = sq_diff5(ka[15:11], kb[15:11]);
        sb = sq_diff5(ka[7:3],   kb[7:3]);
        return DIST_W'({sr, 1'b0}) + DIST_W'({sg, 2'b00}) + DIST_W'({sb, 1'b0})
             + DIST_W'(sb);
    endfunction

endpackage

FILE: sv/rgb_to_palette_index_quantizer_unit.sv
// Path from accept to m_valid: padding or transparent pixels go straight to the done state;
// a hit on entry i ends the scan there; a miss after all used entries allocates the next one;
// when the palette is full a nearest-color search follows, ending early on a zero distance.
// Throughput: one pixel at a time, one key read per cycle; s_ready rises with m_valid, and
// a finished pixel waits in the done state while the previous result beat is still waiting.
// Reset: synchronous active-low; palette count back to one, cutoff to 127, keys left as is.
`include "rgb_to_palette_index_quantizer_unit_macros.svh"

module rgb_to_palette_index_quantizer_unit
    import rtpq_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_image,
    input  logic        s_outside,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_alpha,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_color_index,
    output logic        m_entry_added,
    output logic [15:0] m_entry_color
);

    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
    localparam int DEPTH = PALETTE_ENTRIES - 1;
    localparam int AW    = (PALETTE_ENTRIES > 2) ? $clog2(PALETTE_ENTRIES - 1) : 1;
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PALETTE_ENTRIES);
    localparam logic [7:0]       CUTOFF_RESET = 8'd127;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_NEAR = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Control state
    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [7:0]        cutoff_reg, cutoff_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              m_valid_reg, m_valid_next;

    // Payload state
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic [CNT_W-1:0]  best_idx_reg, best_idx_next;
    logic [7:0]        res_idx_reg, res_idx_next;
    logic              res_added_reg, res_added_next;
    logic [7:0]        m_idx_reg;
    logic              m_added_reg;
    logic [15:0]       m_color_reg;

    // Palette key memory
    logic [KEY_W-1:0]  key_mem [DEPTH];

    logic              accept;
    logic              issue;
    logic              hit;
    logic              out_free;
    logic              mem_we;
    logic [CNT_W-1:0]  rd_addr_full;
    logic [CNT_W-1:0]  wr_addr_full;
    logic [DIST_W-1:0] cand_dist;
    logic [15:0]       new_word;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign issue        = (ptr_reg < used_reg);
    assign hit          = rd_vld_reg && (rd_key_reg == key_reg);
    assign rd_addr_full = ptr_reg - CNT_ONE;
    assign wr_addr_full = used_reg - CNT_ONE;
    assign cand_dist    = weighted_dist(rd_key_reg, key_reg);
    assign new_word     = {1'b1, key_reg[7:3], key_reg[15:11], key_reg[23:19]};
    assign mem_we       = (state_reg == ST_SCAN) && !hit && !issue && !rd_vld_reg
                          && (used_reg < CNT_FULL);

    // Sequencer: lookup, allocate, nearest search, hand off
    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        cutoff_next    = cfg_we ? cfg_wdata : cutoff_reg;
        ptr_next       = ptr_reg;
        rd_vld_next    = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        res_idx_next   = res_idx_reg;
        res_added_next = res_added_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_idx_next   = TRANSPARENT_IDX;
                    res_added_next = 1'b0;
                    ptr_next       = CNT_ONE;
                    if (s_start_image) begin
                        used_next = CNT_ONE;
                    end
                    if (s_outside || (s_alpha <= cutoff_reg)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    res_idx_next = 8'(rd_idx_reg);
                    state_next   = ST_DONE;
                end else if (issue) begin
                    ptr_next    = ptr_reg + CNT_ONE;
                    rd_vld_next = 1'b1;
                end else if (!rd_vld_reg) begin
                    if (used_reg < CNT_FULL) begin
                        res_idx_next   = 8'(used_reg);
                        res_added_next = 1'b1;
                        used_next      = used_reg + CNT_ONE;
                        state_next     = ST_DONE;
                    end else begin
                        ptr_next       = CNT_ONE;
                        best_dist_next = DIST_MAX;
                        best_idx_next  = CNT_ONE;
                        state_next     = ST_NEAR;
                    end
                end
            end
            ST_NEAR: begin
                if (rd_vld_reg && (cand_dist == '0)) begin
                    res_idx_next = 8'(rd_idx_reg);
                    state_next   = ST_DONE;
                end else begin
                    if (rd_vld_reg && (cand_dist < best_dist_reg)) begin
                        best_dist_next = cand_dist;
                        best_idx_next  = rd_idx_reg;
                    end
                    if (issue) begin
                        ptr_next    = ptr_reg + CNT_ONE;
                        rd_vld_next = 1'b1;
                    end else if (!rd_vld_reg) begin
                        res_idx_next = 8'(best_idx_reg);
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= CNT_ONE;
            cutoff_reg  <= CUTOFF_RESET;
            ptr_reg     <= CNT_ONE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cutoff_reg  <= cutoff_next;
            ptr_reg     <= ptr_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture the pixel key, search results and the output beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg <= {s_red, s_green, s_blue};
        end
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        res_idx_reg   <= res_idx_next;
        res_added_reg <= res_added_next;
        rd_idx_reg    <= ptr_reg;
        if ((state_reg == ST_DONE) && out_free) begin
            m_idx_reg   <= res_idx_reg;
            m_added_reg <= res_added_reg;
            m_color_reg <= res_added_reg ? new_word : 16'h0000;
        end
    end

    // Key memory: one write for allocation, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[wr_addr_full[AW-1:0]] <= key_reg;
        end
        if (rd_vld_next) begin
            rd_key_reg <= key_mem[rd_addr_full[AW-1:0]];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_color_index = m_idx_reg;
    assign m_entry_added = m_added_reg;
    assign m_entry_color = m_color_reg;

    `RTPQ_ASSERT_NOW(a_used_range, 1'b1, (used_reg >= CNT_ONE) && (used_reg <= CNT_FULL), "palette count out of range")
    `RTPQ_ASSERT_NOW(a_added_word, m_valid && m_entry_added, (m_color_index != TRANSPARENT_IDX) && m_entry_color[15], "new entry beat malformed")
    `RTPQ_ASSERT_NOW(a_read_in_use, rd_vld_reg, (rd_idx_reg < used_reg) && (rd_idx_reg != '0), "read beyond used entries")
    `RTPQ_ASSERT_NEXT(a_alloc_grows, mem_we, used_reg == $past(used_reg) + CNT_ONE, "allocation did not grow palette")

endmodule

FILE: sim/rgb_to_palette_index_quantizer_unit_tb.sv
// Self-checking testbench for the RGBA to palette index quantizer.
// Needs rtpq_pkg and rgb_to_palette_index_quantizer_unit; runs a directed table, then
// random images of small and full palettes against an in-bench palette predictor.
`timescale 1ns / 1ps

module rgb_to_palette_index_quantizer_unit_tb
    import rtpq_pkg::*;
();

    localparam int PALETTE_ENTRIES = 256;
    localparam int TARGET_PIXELS   = 1400;
    localparam int LIMIT_CYCLES    = 4_000_000;
    localparam int DRAIN_CYCLES    = 2 * PALETTE_ENTRIES + 8;
    localparam int IDLE_PCT        = 28;

    typedef struct packed {
        logic       start_image;
        logic       outside;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  color_index;
        logic        entry_added;
        logic [15:0] entry_color;
    } result_t;

    // One beat of stimulus; fixed carries a result typed in by hand
    typedef struct packed {
        pixel_t  pix;
        logic    fixed;
        result_t res;
    } stim_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_start_image = 1'b0;
    logic        s_outside = 1'b0;
    logic [7:0]  s_red = 8'd0;
    logic [7:0]  s_green = 8'd0;
    logic [7:0]  s_blue = 8'd0;
    logic [7:0]  s_alpha = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_color_index;
    logic        m_entry_added;
    logic [15:0] m_entry_color;

    // Side info that travels with the input beat
    logic        drv_fixed = 1'b0;
    result_t     drv_res = '0;

    // Predictor state
    logic [23:0] pal_key [1:PALETTE_ENTRIES-1];
    int          pal_used = 1;
    logic [7:0]  pred_cutoff = 8'd127;

    result_t     pending_results [$];
    stim_t       pixel_q [$];
    stim_t       dir_tab [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          pixel_count = 0;
    logic [7:0]  cur_cutoff = 8'd127;
    bit          no_idle = 1'b0;

    rgb_to_palette_index_quantizer_unit #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_image (s_start_image),
        .s_outside     (s_outside),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_alpha       (s_alpha),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_color_index (m_color_index),
        .m_entry_added (m_entry_added),
        .m_entry_color (m_entry_color)
    );

    always #5 aclk = ~aclk;

    // Palette predictor: exact lookup, then allocate, then nearest 5-bit match
    function automatic result_t quantize_pixel(input pixel_t p);
        result_t     r;
        logic [23:0] key;
        bit          hit;
        int          i;
        int          best;
        longint      best_d;
        longint      d;
        int          dr;
        int          dg;
        int          db;
        int          q5;
        int          k5;
        r = '0;
        r.color_index = TRANSPARENT_IDX;
        if (p.start_image)
            pal_used = 1;
        if (!p.outside && p.alpha > pred_cutoff) begin
            key = {p.red, p.green, p.blue};
            hit = 1'b0;
            for (i = 1; i < pal_used; i++) begin
                if (!hit && pal_key[i] == key) begin
                    r.color_index = 8'(i);
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                if (pal_used < PALETTE_ENTRIES) begin
                    r.color_index = 8'(pal_used);
                    pal_key[pal_used] = key;
                    pal_used++;
                    r.entry_added = 1'b1;
                    r.entry_color = {1'b1, p.blue[7:3], p.green[7:3], p.red[7:3]};
                end else begin
                    best = 1;
                    best_d = 64'h7FFF_FFFF_FFFF;
                    for (i = 1; i < pal_used; i++) begin
                        if (best_d != 0) begin
                            q5 = p.red[7:3];   k5 = pal_key[i][23:19]; dr = q5 - k5;
                            q5 = p.green[7:3]; k5 = pal_key[i][15:11]; dg = q5 - k5;
                            q5 = p.blue[7:3];  k5 = pal_key[i][7:3];   db = q5 - k5;
                            d = 2 * dr * dr + 4 * dg * dg + 3 * db * db;
                            if (d < best_d) begin
                                best_d = d;
                                best = i;
                            end
                        end
                    end
                    r.color_index = 8'(best);
                end
            end
        end
        return r;
    endfunction

    // Predict on every input beat, check every output beat
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (cfg_we)
                pred_cutoff = cfg_wdata;
            if (s_valid && s_ready) begin
                want = quantize_pixel({s_start_image, s_outside, s_red, s_green, s_blue,
                                       s_alpha});
                pending_results.insert(pending_results.size(), drv_fixed ? drv_res : want);
            end
            if (m_valid && m_ready) begin
                got = {m_color_index, m_entry_added, m_entry_color};
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: idx %0d added %0d color %h",
                                 m_color_index, m_entry_added, m_entry_color);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected idx %0d added %0d color %h, got idx %0d added %0d color %h",
                                     want.color_index, want.entry_added, want.entry_color,
                                     m_color_index, m_entry_added, m_entry_color);
                    end
                end
            end
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Hard stop
    initial begin
        while (cycle_count < LIMIT_CYCLES)
            @(posedge aclk);
        $display("rgb_to_palette_index_quantizer_unit regression: fail");
        $finish;
    end

    task automatic add_row(input bit st, input bit outs, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b, input logic [7:0] a,
                           input bit fixed, input logic [7:0] idx, input bit added,
                           input logic [15:0] color);
        stim_t row;
        row.pix   = {st, outs, r, g, b, a};
        row.fixed = fixed;
        row.res   = {idx, added, color};
        dir_tab.insert(dir_tab.size(), row);
    endtask

    task automatic push_pixel(input bit st, input bit outs, input logic [23:0] key,
                              input logic [7:0] a);
        stim_t s;
        s.pix   = {st, outs, key, a};
        s.fixed = 1'b0;
        s.res   = '0;
        pixel_q.insert(pixel_q.size(), s);
        pixel_count++;
    endtask

    // Drive queued beats; called and returns at a falling edge
    task automatic play_pixels();
        stim_t s;
        while (pixel_q.size() != 0) begin
            s = pixel_q.pop_front();
            while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid       <= 1'b1;
            s_start_image <= s.pix.start_image;
            s_outside     <= s.pix.outside;
            s_red         <= s.pix.red;
            s_green       <= s.pix.green;
            s_blue        <= s.pix.blue;
            s_alpha       <= s.pix.alpha;
            drv_fixed     <= s.fixed;
            drv_res       <= s.res;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
            @(negedge aclk);
        end
        s_valid <= 1'b0;
    endtask

    // Write the cutoff once every result is back
    task automatic write_cutoff(input logic [7:0] v);
        while (pending_results.size() != 0)
            @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        cur_cutoff = v;
    endtask

    function automatic logic [7:0] opaque_alpha();
        if (cur_cutoff == 8'd255)
            return 8'd255;
        return 8'($urandom_range(int'(cur_cutoff) + 1, 255));
    endfunction

    function automatic logic [7:0] pick_alpha();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 12)
            return 8'($urandom_range(0, 255));
        if (sel < 24) begin
            v = int'(cur_cutoff) + $urandom_range(0, 2) - 1;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return 8'(v);
        end
        return opaque_alpha();
    endfunction

    // Nonzero jitter in the three low bits of each channel
    function automatic logic [23:0] low_jitter();
        logic [23:0] m;
        m = 24'($urandom) & 24'h070707;
        if (m == 24'd0)
            m = 24'h000001;
        return m;
    endfunction

    // Short image over a small color pool, with some padding and stray starts
    task automatic gen_small_image();
        logic [23:0] pool [12];
        logic [23:0] key;
        int          n;
        int          k;
        int          j;
        int          sel;
        n = $urandom_range(4, 40);
        k = $urandom_range(1, 12);
        for (j = 0; j < k; j++)
            pool[j] = 24'($urandom);
        for (j = 0; j < n; j++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                key = pool[$urandom_range(0, k - 1)];
            else if (sel < 80)
                key = pool[$urandom_range(0, k - 1)] ^ low_jitter();
            else
                key = 24'($urandom);
            push_pixel((j == 0) || ($urandom_range(0, 99) < 3), $urandom_range(0, 99) < 10,
                       key, pick_alpha());
        end
    endtask

    // Fill all entries, then query the full palette
    task automatic gen_full_image();
        logic [23:0] fill [$];
        logic [23:0] base;
        logic [23:0] stride;
        logic [23:0] key;
        int          j;
        int          q;
        int          sel;
        base   = 24'($urandom);
        stride = 24'($urandom) | 24'd1;
        for (j = 0; j < PALETTE_ENTRIES + 2; j++) begin
            // twins share the 5-bit color of the previous entry, forcing ties later
            if (j > 0 && j < PALETTE_ENTRIES - 1 && $urandom_range(0, 99) < 20)
                key = fill[fill.size() - 1] ^ low_jitter();
            else
                key = base + stride * 24'(j);
            push_pixel(j == 0, 1'b0, key, opaque_alpha());
            fill.insert(fill.size(), key);
            if ($urandom_range(0, 99) < 8) begin
                sel = $urandom_range(0, 2);
                if (sel == 0)
                    push_pixel(1'b0, 1'b1, 24'($urandom), 8'($urandom));
                else if (sel == 1)
                    push_pixel(1'b0, 1'b0, 24'($urandom),
                               8'($urandom_range(0, int'(cur_cutoff))));
                else
                    push_pixel(1'b0, 1'b0, fill[$urandom_range(0, fill.size() - 1)],
                               opaque_alpha());
            end
        end
        q = $urandom_range(40, 70);
        for (j = 0; j < q; j++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                push_pixel(1'b0, 1'b0, fill[$urandom_range(0, fill.size() - 1)],
                           opaque_alpha());
            else if (sel < 65)
                push_pixel(1'b0, 1'b0,
                           fill[$urandom_range(0, fill.size() - 1)] ^ low_jitter(),
                           opaque_alpha());
            else if (sel < 90)
                push_pixel(1'b0, 1'b0, 24'($urandom), opaque_alpha());
            else if (sel < 95)
                push_pixel(1'b0, 1'b1, 24'($urandom), 8'($urandom));
            else
                push_pixel(1'b0, 1'b0, 24'($urandom), 8'($urandom_range(0, int'(cur_cutoff))));
        end
    endtask

    initial begin
        int img;
        int phase_no;
        int k;

        // Directed table under the reset cutoff
        add_row(1, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 1, 8'd1, 1, 16'h8000); // black opaque
        add_row(0, 0, 8'h00, 8'h00, 8'h00, 8'hC8, 1, 8'd1, 0, 16'h0000);
        add_row(0, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 8'd0, 0, 16'h0000); // padding
        add_row(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 1, 8'd0, 0, 16'h0000); // at cutoff
        add_row(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'h80, 1, 8'd2, 1, 16'hFFFF);
        add_row(0, 0, 8'hFF, 8'h00, 8'h00, 8'hFF, 1, 8'd3, 1, 16'h801F);
        add_row(0, 0, 8'h00, 8'hFF, 8'h00, 8'hFF, 1, 8'd4, 1, 16'h83E0);
        add_row(0, 0, 8'h00, 8'h00, 8'hFF, 8'hFF, 1, 8'd5, 1, 16'hFC00);
        add_row(0, 0, 8'h07, 8'h07, 8'h07, 8'hFF, 1, 8'd6, 1, 16'h8000);
        add_row(0, 0, 8'hFF, 8'h00, 8'h00, 8'h00, 1, 8'd0, 0, 16'h0000);
        add_row(0, 0, 8'hFF, 8'h00, 8'h00, 8'h82, 1, 8'd3, 0, 16'h0000);
        add_row(0, 0, 8'h12, 8'h34, 8'h56, 8'hC8, 0, 8'd0, 0, 16'h0000);
        add_row(0, 0, 8'hA5, 8'h5A, 8'hF0, 8'h81, 0, 8'd0, 0, 16'h0000);
        add_row(0, 0, 8'h12, 8'h34, 8'h56, 8'hFF, 0, 8'd0, 0, 16'h0000);
        add_row(1, 1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 8'd0, 0, 16'h0000); // padding with start
        add_row(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 8'd1, 1, 16'hFFFF);
        add_row(0, 0, 8'h00, 8'h00, 8'h00, 8'hFF, 1, 8'd2, 1, 16'h8000);
        add_row(0, 0, 8'h80, 8'h7F, 8'h01, 8'h80, 0, 8'd0, 0, 16'h0000);
        add_row(0, 0, 8'h7F, 8'h80, 8'hFE, 8'hFE, 0, 8'd0, 0, 16'h0000);
        add_row(1, 0, 8'h55, 8'hAA, 8'h33, 8'h99, 0, 8'd0, 0, 16'h0000);

        // Hold reset, then release it on a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (k = 0; k < dir_tab.size(); k++) begin
            pixel_q.insert(pixel_q.size(), dir_tab[k]);
            pixel_count++;
        end
        play_pixels();

        // Random images, changing the cutoff between some of them
        img = 0;
        phase_no = 0;
        while (pixel_count < TARGET_PIXELS) begin
            if (img == 0 || $urandom_range(0, 99) < 30) begin
                case (phase_no % 6)
                    0: write_cutoff(8'd0);
                    1: write_cutoff(8'd255);
                    2: write_cutoff(8'd1);
                    3: write_cutoff(8'd254);
                    4: write_cutoff(8'd127);
                    default: write_cutoff(8'($urandom));
                endcase
                phase_no++;
            end
            if (img % 4 == 1 && cur_cutoff == 8'd255)
                write_cutoff(8'($urandom_range(0, 200)));
            no_idle = (img == 2 || img == 3);
            if (img % 4 == 1)
                gen_full_image();
            else
                gen_small_image();
            play_pixels();
            img++;
        end
        no_idle = 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("rgb_to_palette_index_quantizer_unit regression: pass");
        else
            $display("rgb_to_palette_index_quantizer_unit regression: fail");
        $finish;
    end

endmodule
